// ===== rtl/core/utcc_pkg.sv =====
// Shared types and constants for the UTF-8 text console cursor core.
// Used by the front decoder, the command queue, the cursor engine and the top level.
// No dependencies.
package utcc_pkg;

	localparam int TAB_STOP_DEF = 4;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd25;
	localparam logic [7:0] COLUMNS_MIN   = 8'd2;
	localparam logic [7:0] ROWS_MIN      = 8'd1;

	localparam logic [7:0] CH_BACKSPACE  = 8'd8;
	localparam logic [7:0] CH_TAB        = 8'd9;
	localparam logic [7:0] CH_NEWLINE    = 8'd10;
	localparam logic [7:0] CH_RETURN     = 8'd13;
	localparam logic [7:0] CH_SPACE      = 8'd32;
	localparam logic [7:0] CH_LAST_PRINT = 8'd126;
	localparam logic [7:0] CH_QUESTION   = 8'd63;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;

	typedef enum logic [2:0] {
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_TAB,
		OP_OTHER,
		OP_NARROW,
		OP_WIDE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] glyph;
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NARROW = 2'd0,
		ACT_WIDE   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_SCROLL = 2'd3
	} act_t;

endpackage

// ===== rtl/core/utcc_front.sv =====
// Front decoder: accepts text bytes, assembles UTF-8 sequences and classifies them.
// Depends on utcc_pkg; pushes classified commands into utcc_queue.
module utcc_front import utcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] text_byte,
	input  logic       queue_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [15:0] partial_q;
	logic [1:0]  pending_q;
	logic [15:0] partial_d;
	logic [1:0]  pending_d;
	logic [15:0] merged;
	logic        accept;
	logic        emit;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;
	assign merged     = {partial_q[9:0], text_byte[5:0]};
	assign push       = accept && emit;

	always_comb begin
		partial_d      = partial_q;
		pending_d      = pending_q;
		emit           = 1'b0;
		push_cmd.op    = OP_OTHER;
		push_cmd.glyph = {8'd0, text_byte};
		priority if (pending_q != 2'd0) begin
			partial_d = merged;
			pending_d = pending_q - 2'd1;
			if (pending_q == 2'd1) begin
				emit           = 1'b1;
				push_cmd.op    = OP_WIDE;
				push_cmd.glyph = merged;
			end
		end else if (!text_byte[7]) begin
			emit = 1'b1;
			priority if (text_byte == CH_NEWLINE) begin
				push_cmd.op = OP_NEWLINE;
			end else if (text_byte == CH_RETURN) begin
				push_cmd.op = OP_RETURN;
			end else if (text_byte == CH_BACKSPACE) begin
				push_cmd.op = OP_BACKSPACE;
			end else if (text_byte == CH_TAB) begin
				push_cmd.op = OP_TAB;
			end else if (text_byte < CH_SPACE) begin
				push_cmd.op = OP_OTHER;
			end else begin
				push_cmd.op = OP_NARROW;
				if (text_byte > CH_LAST_PRINT) begin
					push_cmd.glyph = {8'd0, CH_QUESTION};
				end
			end
		end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
			partial_d = {11'd0, text_byte[4:0]};
			pending_d = 2'd1;
		end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
			partial_d = {12'd0, text_byte[3:0]};
			pending_d = 2'd2;
		end else begin
			emit        = 1'b1;
			push_cmd.op = OP_WIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 16'd0;
			pending_q <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_d;
			pending_q <= pending_d;
		end
	end

endmodule

// ===== rtl/core/utcc_queue.sv =====
// Short command queue between the front decoder and the cursor engine.
// Depends on utcc_pkg for the command type.
module utcc_queue import utcc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/utcc_back.sv =====
// Cursor engine: carries out queued commands, keeps the cursor and issues cell commands.
// Depends on utcc_pkg; reads the head of utcc_queue and drives the result register.
module utcc_back import utcc_pkg::*; #(
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  logic        head_valid,
	output logic        pop,
	input  logic [7:0]  eff_cols,
	input  logic [7:0]  eff_rows,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  action,
	output logic [7:0]  cell_column,
	output logic [7:0]  cell_row,
	output logic [15:0] glyph_code,
	output logic        last
);

	localparam int MOD_W = $clog2(TAB_STOP);
	localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(TAB_STOP - 1);
	localparam logic [MOD_W:0]   MOD_WRAP = (MOD_W + 1)'(TAB_STOP);
	localparam logic [8:0]       TAB_ADV  = 9'(TAB_STOP);

	typedef enum logic [2:0] {
		ST_HEAD = 3'b001,
		ST_MAIN = 3'b010,
		ST_POST = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [7:0]       col_q, col_d;
	logic [8:0]       row_q, row_d;
	logic [MOD_W-1:0] mod_q, mod_d;

	logic        res_valid_q;
	act_t        res_act_q;
	logic [7:0]  res_col_q;
	logic [7:0]  res_row_q;
	logic [15:0] res_glyph_q;
	logic        res_last_q;

	logic        out_free;
	logic [7:0]  last_row;

	logic        pre_wrap;
	logic [8:0]  pre_row;
	logic        pre_scroll;

	logic [8:0]       c1;
	logic [8:0]       r1;
	logic [MOD_W-1:0] mod_main;
	logic [MOD_W-1:0] mod_inc1;
	logic [MOD_W:0]   mod_sum2;
	logic [MOD_W-1:0] mod_inc2;
	logic             main_emit;
	act_t             main_act;
	logic [7:0]       main_col;
	logic [15:0]      main_glyph;
	logic             main_wrap;
	logic [7:0]       c2;
	logic [8:0]       r2;
	logic [MOD_W-1:0] mod2;
	logic             main_scroll;
	logic             main_go;

	logic        do_emit;
	act_t        emit_act;
	logic [7:0]  emit_col;
	logic [7:0]  emit_row;
	logic [15:0] emit_glyph;
	logic        emit_last;

	assign out_free = !res_valid_q || result_ready;
	assign last_row = eff_rows - 8'd1;

	assign pre_wrap   = (col_q >= eff_cols - 8'd1);
	assign pre_row    = pre_wrap ? row_q + 9'd1 : row_q;
	assign pre_scroll = (pre_row >= {1'b0, eff_rows});

	assign mod_inc1 = (mod_q == MOD_LAST) ? '0 : mod_q + MOD_W'(1);
	assign mod_sum2 = {1'b0, mod_q} + (MOD_W + 1)'(2);
	assign mod_inc2 = (mod_sum2 >= MOD_WRAP) ? MOD_W'(mod_sum2 - MOD_WRAP) : mod_sum2[MOD_W-1:0];

	always_comb begin
		c1         = {1'b0, col_q};
		r1         = row_q;
		mod_main   = mod_q;
		main_emit  = 1'b0;
		main_act   = ACT_NARROW;
		main_col   = col_q;
		main_glyph = head.glyph;
		unique case (head.op)
			OP_NEWLINE: begin
				c1       = 9'd0;
				r1       = row_q + 9'd1;
				mod_main = '0;
			end
			OP_RETURN: begin
				c1       = 9'd0;
				mod_main = '0;
			end
			OP_BACKSPACE: begin
				if (col_q != 8'd0) begin
					c1         = {1'b0, col_q - 8'd1};
					main_emit  = 1'b1;
					main_act   = ACT_CLEAR;
					main_col   = col_q - 8'd1;
					main_glyph = 16'd0;
					mod_main   = (mod_q == '0) ? MOD_LAST : mod_q - MOD_W'(1);
				end
			end
			OP_TAB: begin
				c1       = {1'b0, col_q} + TAB_ADV - 9'(mod_q);
				mod_main = '0;
			end
			OP_NARROW: begin
				c1        = {1'b0, col_q} + 9'd1;
				main_emit = 1'b1;
				main_act  = ACT_NARROW;
				mod_main  = mod_inc1;
			end
			OP_WIDE: begin
				c1        = {1'b0, col_q} + 9'd2;
				main_emit = 1'b1;
				main_act  = ACT_WIDE;
				mod_main  = mod_inc2;
			end
			default: begin
				c1 = {1'b0, col_q};
			end
		endcase
		main_wrap   = (c1 >= {1'b0, eff_cols});
		c2          = main_wrap ? 8'd0 : c1[7:0];
		r2          = main_wrap ? r1 + 9'd1 : r1;
		mod2        = main_wrap ? '0 : mod_main;
		main_scroll = (r2 >= {1'b0, eff_rows});
	end

	assign main_go = ((state_q == ST_HEAD) && head_valid && (head.op != OP_WIDE))
		|| (state_q == ST_MAIN);

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		mod_d      = mod_q;
		pop        = 1'b0;
		do_emit    = 1'b0;
		emit_act   = ACT_SCROLL;
		emit_col   = 8'd0;
		emit_row   = last_row;
		emit_glyph = 16'd0;
		emit_last  = 1'b0;
		if (main_go) begin
			if (!main_emit || out_free) begin
				do_emit    = main_emit;
				emit_act   = main_act;
				emit_col   = main_col;
				emit_row   = row_q[7:0];
				emit_glyph = main_glyph;
				emit_last  = !main_scroll;
				col_d      = c2;
				row_d      = r2;
				mod_d      = mod2;
				if (main_scroll) begin
					state_d = ST_POST;
				end else begin
					pop     = 1'b1;
					state_d = ST_HEAD;
				end
			end
		end else if (state_q == ST_HEAD) begin
			if (head_valid && (!pre_scroll || out_free)) begin
				state_d = ST_MAIN;
				if (pre_scroll) begin
					do_emit = 1'b1;
					col_d   = 8'd0;
					row_d   = {1'b0, last_row};
					mod_d   = '0;
				end else begin
					col_d = pre_wrap ? 8'd0 : col_q;
					row_d = pre_row;
					mod_d = pre_wrap ? '0 : mod_q;
				end
			end
		end else if (state_q == ST_POST) begin
			if (out_free) begin
				do_emit   = 1'b1;
				emit_last = 1'b1;
				col_d     = 8'd0;
				row_d     = {1'b0, last_row};
				mod_d     = '0;
				pop       = 1'b1;
				state_d   = ST_HEAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HEAD;
			col_q       <= 8'd0;
			row_q       <= 9'd0;
			mod_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			mod_q   <= mod_d;
			if (do_emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			res_act_q   <= emit_act;
			res_col_q   <= emit_col;
			res_row_q   <= emit_row;
			res_glyph_q <= emit_glyph;
			res_last_q  <= emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign action       = res_act_q;
	assign cell_column  = res_col_q;
	assign cell_row     = res_row_q;
	assign glyph_code   = res_glyph_q;
	assign last         = res_last_q;

endmodule

// ===== rtl/core/utf8_text_console_cursor_core.sv =====
// Top level of the UTF-8 text console cursor core: configuration registers and block wiring.
// Depends on utcc_pkg, utcc_front, utcc_queue and utcc_back.
//
// The core takes UTF-8 text one byte per transaction and answers with cell commands
// (draw narrow, draw wide, clear cell, scroll up) for a columns-by-rows grid. The front
// decoder accepts a byte whenever the command queue is not full and queues one command
// per complete character; lead and middle bytes of a sequence leave no command. The cursor
// engine carries out each command in steps: a main step that moves the cursor and issues
// any draw or clear, preceded for a wide glyph by a step that wraps the cursor if the glyph
// would not fit, and followed by a scroll step when the cursor leaves the last row. Each
// cell command is held in an output register, and a two-entry command queue lets the front
// keep taking bytes while the engine waits on a stalled result. Configuration writes take
// effect on the next cycle and should be made while the core is idle.
module utf8_text_console_cursor_core import utcc_pkg::*; #(
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  text_byte,
	input  logic        write_enable,
	input  logic        write_index,
	input  logic [7:0]  write_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  action,
	output logic [7:0]  cell_column,
	output logic [7:0]  cell_row,
	output logic [15:0] glyph_code,
	output logic        last
);

	logic [7:0] columns_q;
	logic [7:0] rows_q;
	logic [7:0] eff_cols;
	logic [7:0] eff_rows;

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (write_enable) begin
			unique case (write_index)
				REG_COLUMNS: columns_q <= write_data;
				REG_ROWS:    rows_q    <= write_data;
				default:     columns_q <= columns_q;
			endcase
		end
	end

	assign eff_cols = (columns_q < COLUMNS_MIN) ? COLUMNS_MIN : columns_q;
	assign eff_rows = (rows_q < ROWS_MIN) ? ROWS_MIN : rows_q;

	utcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.text_byte  (text_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	utcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	utcc_back #(
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.eff_cols     (eff_cols),
		.eff_rows     (eff_rows),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.action       (action),
		.cell_column  (cell_column),
		.cell_row     (cell_row),
		.glyph_code   (glyph_code),
		.last         (last)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for utf8_text_console_cursor_core: directed and random UTF-8 text,
// checked against a cursor and decoder predictor kept in step with each accepted byte.
// Depends on utcc_pkg and the core RTL.
module testbench;
	import utcc_pkg::*;

	localparam int TAB         = TAB_STOP_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int GAP_PCT     = 31;

	typedef struct packed {
		act_t        action;
		logic [7:0]  column;
		logic [7:0]  row;
		logic [15:0] glyph;
		logic        last;
	} cell_cmd_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_ready;
	logic [7:0]  text_byte    = 8'd0;
	logic        write_enable = 1'b0;
	logic        write_index  = REG_COLUMNS;
	logic [7:0]  write_data   = 8'd0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  action;
	logic [7:0]  cell_column;
	logic [7:0]  cell_row;
	logic [15:0] glyph_code;
	logic        last;

	utf8_text_console_cursor_core #(.TAB_STOP(TAB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.text_byte(text_byte),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.action(action),
		.cell_column(cell_column),
		.cell_row(cell_row),
		.glyph_code(glyph_code),
		.last(last)
	);

	always #4 clk = ~clk;

	// Predictor state.
	logic [7:0]  grid_cols;
	logic [7:0]  grid_rows;
	int          cur_col;
	int          cur_row;
	logic [15:0] partial_code;
	logic [1:0]  bytes_left;
	cell_cmd_t   step_cmds[$];
	cell_cmd_t   cell_cmds_due[$];

	int error_count   = 0;
	int bytes_offered = 0;
	int cycle_count;
	bit send_gaps     = 1'b1;
	bit ready_gaps    = 1'b1;
	int hold_ticket   = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	function automatic int grid_width();
		return (grid_cols < COLUMNS_MIN) ? COLUMNS_MIN : grid_cols;
	endfunction

	function automatic int grid_height();
		return (grid_rows < ROWS_MIN) ? ROWS_MIN : grid_rows;
	endfunction

	function automatic void add_cmd(act_t act, int col, int row, int glyph);
		cell_cmd_t c;
		c.action = act;
		c.column = col[7:0];
		c.row    = row[7:0];
		c.glyph  = glyph[15:0];
		c.last   = 1'b0;
		step_cmds.push_back(c);
	endfunction

	function automatic void scroll_if_below();
		if (cur_row >= grid_height()) begin
			add_cmd(ACT_SCROLL, 0, grid_height() - 1, 0);
			cur_row = grid_height() - 1;
			cur_col = 0;
		end
	endfunction

	function automatic void settle_cursor();
		if (cur_col >= grid_width()) begin
			cur_col = 0;
			cur_row++;
		end
		scroll_if_below();
	endfunction

	function automatic void put_ascii(logic [7:0] c);
		if (c == CH_NEWLINE) begin
			cur_col = 0;
			cur_row++;
		end else if (c == CH_RETURN) begin
			cur_col = 0;
		end else if (c == CH_BACKSPACE) begin
			if (cur_col > 0) begin
				cur_col--;
				add_cmd(ACT_CLEAR, cur_col, cur_row, 0);
			end
		end else if (c == CH_TAB) begin
			cur_col = cur_col + TAB - (cur_col % TAB);
			if (cur_col >= grid_width()) begin
				cur_col = 0;
				cur_row++;
			end
		end else if (c >= CH_SPACE) begin
			add_cmd(ACT_NARROW, cur_col, cur_row, (c > CH_LAST_PRINT) ? CH_QUESTION : c);
			cur_col++;
		end
		settle_cursor();
	endfunction

	function automatic void put_wide(int code);
		if (cur_col >= grid_width() - 1) begin
			cur_col = 0;
			cur_row++;
		end
		scroll_if_below();
		add_cmd(ACT_WIDE, cur_col, cur_row, code);
		cur_col += 2;
		settle_cursor();
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		cell_cmd_t c;
		step_cmds.delete();
		if (bytes_left != 2'd0) begin
			partial_code = {partial_code[9:0], b[5:0]};
			bytes_left   = bytes_left - 2'd1;
			if (bytes_left == 2'd0)
				put_wide(partial_code);
		end else if (!b[7]) begin
			put_ascii(b);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			partial_code = {11'd0, b[4:0]};
			bytes_left   = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			partial_code = {12'd0, b[3:0]};
			bytes_left   = 2'd2;
		end else begin
			put_wide(b);
		end
		foreach (step_cmds[i]) begin
			c      = step_cmds[i];
			c.last = (i == step_cmds.size() - 1);
			cell_cmds_due.push_back(c);
		end
		cur_col = cur_col % 256;
		cur_row = cur_row % 256;
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Results are sampled at the falling edge, where the handshake for the next rising edge
	// is already settled.
	always @(negedge clk) begin
		cell_cmd_t want;
		if (arst_n && result_valid && result_ready) begin
			if (cell_cmds_due.size() == 0) begin
				error_count++;
				$display("%0t: unexpected transaction, expected none, actual %0d %0h %0h %0h %0b",
					$time, action, cell_column, cell_row, glyph_code, last);
			end else begin
				want = cell_cmds_due.pop_front();
				compare_field("action", want.action, action);
				compare_field("cell_column", want.column, cell_column);
				compare_field("cell_row", want.row, cell_row);
				compare_field("glyph_code", want.glyph, glyph_code);
				compare_field("last", want.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (ready_gaps && $urandom_range(99) < GAP_PCT) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_byte(logic [7:0] b);
		if (send_gaps && $urandom_range(99) < GAP_PCT) begin
			byte_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < GAP_PCT);
		end
		byte_valid <= 1'b1;
		text_byte  <= b;
		bytes_offered++;
		do @(negedge clk); while (!byte_ready);
		@(posedge clk);
		decode_byte(b);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (cell_cmds_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grid(logic [7:0] cols, logic [7:0] rows);
		write_enable <= 1'b1;
		write_index  <= REG_COLUMNS;
		write_data   <= cols;
		@(posedge clk);
		grid_cols   = cols;
		write_index <= REG_ROWS;
		write_data  <= rows;
		@(posedge clk);
		grid_rows     = rows;
		write_enable <= 1'b0;
	endtask

	task automatic reset_core();
		grid_cols    = COLUMNS_RESET;
		grid_rows    = ROWS_RESET;
		cur_col      = 0;
		cur_row      = 0;
		partial_code = 16'd0;
		bytes_left   = 2'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_basic_text();
		logic [7:0] seq[$];
		seq = '{8'h00, CH_BACKSPACE, 8'h41, CH_SPACE, CH_LAST_PRINT, 8'h7F, CH_BACKSPACE,
			CH_TAB, 8'h1F, CH_RETURN, CH_NEWLINE, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'h80, 8'hF0, 8'hFF, 8'hC2, 8'h7F};
		foreach (seq[i])
			send_byte(seq[i]);
		drain();
	endtask

	task automatic test_smallest_grid();
		set_grid(COLUMNS_MIN, ROWS_MIN);
		send_byte(8'h61);
		send_byte(8'hF5);
		send_byte(CH_TAB);
		drain();
		set_grid(8'd0, 8'd0);
		send_byte(8'h62);
		send_byte(8'h63);
		send_byte(CH_NEWLINE);
		drain();
		set_grid(8'd1, 8'd255);
		send_byte(8'hBF);
		send_byte(8'h64);
		drain();
	endtask

	task automatic test_cursor_off_grid();
		set_grid(8'd255, 8'd255);
		send_byte(CH_NEWLINE);
		send_byte(CH_NEWLINE);
		repeat (4) send_byte(CH_TAB);
		drain();
		set_grid(8'd10, 8'd2);
		send_byte(CH_BACKSPACE);
		send_byte(8'h5A);
		send_byte(8'hFE);
		drain();
	endtask

	task automatic test_output_stall();
		set_grid(8'd20, 8'd4);
		send_gaps   <= 1'b0;
		hold_ticket <= hold_ticket + 1;
		repeat (12) send_byte(8'($urandom_range(32, 127)));
		drain();
		send_gaps <= 1'b1;
	endtask

	task automatic send_random_char();
		int kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			send_byte(8'($urandom_range(32, 127)));
		end else if (kind < 50) begin
			case ($urandom_range(4))
				0: send_byte(CH_BACKSPACE);
				1: send_byte(CH_TAB);
				2: send_byte(CH_NEWLINE);
				3: send_byte(CH_RETURN);
				default: send_byte(8'($urandom_range(31)));
			endcase
		end else if (kind < 68) begin
			send_byte(LEAD2_CODE | 8'($urandom_range(31)));
			send_byte(8'h80 | 8'($urandom_range(63)));
		end else if (kind < 86) begin
			send_byte(LEAD3_CODE | 8'($urandom_range(15)));
			send_byte(8'h80 | 8'($urandom_range(63)));
			send_byte(8'h80 | 8'($urandom_range(63)));
		end else if (kind < 93) begin
			send_byte(8'($urandom_range(255)));
		end else if ($urandom_range(1)) begin
			send_byte(8'($urandom_range(8'h80, 8'hBF)));
		end else begin
			send_byte(8'($urandom_range(8'hF0, 8'hFF)));
		end
	endtask

	task automatic test_random_text();
		int start;
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: set_grid(COLUMNS_RESET, ROWS_RESET);
				1: set_grid(COLUMNS_MIN, ROWS_MIN);
				2: set_grid(8'd255, 8'd255);
				3: set_grid(8'($urandom_range(2, 20)), 8'($urandom_range(1, 6)));
				4: set_grid(8'd255, ROWS_MIN);
				default: set_grid(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			send_gaps  <= (phase != 3);
			ready_gaps <= (phase != 3);
			start = bytes_offered;
			while (bytes_offered - start < 22)
				send_random_char();
		end
		drain();
		send_gaps  <= 1'b1;
		ready_gaps <= 1'b1;
	endtask

	initial begin
		reset_core();
		test_basic_text();
		test_smallest_grid();
		test_cursor_off_grid();
		test_output_stall();
		test_random_text();
		drain();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
